@@ rtl/core/gfp_pkg.sv @@
// gfp_pkg: shared types and constants for the binary GPS frame parser.
// No dependencies; used by every module in rtl/core.
package gfp_pkg;

    localparam logic [7:0]  SYNC_FIRST    = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND   = 8'h62;
    localparam logic [15:0] MAX_LEN_RESET = 16'd512;

    // result kinds
    localparam logic [1:0] KIND_TEXT    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;
    localparam logic [1:0] KIND_ABORT   = 2'd3;

    // frame end check status
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_BAD_A = 2'd1;
    localparam logic [1:0] STATUS_BAD_B = 2'd2;

    typedef enum logic [8:0] {
        PH_HUNT    = 9'b000000001,
        PH_SYNC2   = 9'b000000010,
        PH_CLASS   = 9'b000000100,
        PH_ID      = 9'b000001000,
        PH_LEN_LO  = 9'b000010000,
        PH_LEN_HI  = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_CHECK_A = 9'b010000000,
        PH_CHECK_B = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [7:0]  frame_class;
        logic [7:0]  frame_id;
        logic [15:0] byte_index;
        logic [15:0] frame_length;
        logic [1:0]  check_status;
    } result_t;

endpackage

@@ rtl/core/gfp_parse_core.sv @@
// gfp_parse_core: frame state machine, header capture and Fletcher-8 sums.
// Depends on gfp_pkg. State advances on every accepted item.
module gfp_parse_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    input  logic [15:0]       max_len,
    output logic              res_valid,
    output gfp_pkg::result_t  res
);

    gfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;

    logic [7:0]  add_a;
    logic [7:0]  add_b;
    logic [15:0] full_len;
    logic [15:0] count_inc;

    // running Fletcher step with the current byte
    assign add_a     = sum_a_reg + rx_byte;
    assign add_b     = sum_b_reg + add_a;
    assign full_len  = {rx_byte, len_reg[7:0]};
    assign count_inc = count_reg + 16'd1;

    always_comb
    begin
        phase_next = phase_reg;
        class_next = class_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        count_next = count_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        res_valid  = 1'b0;
        res        = '0;

        case (phase_reg)
            gfp_pkg::PH_SYNC2:
            begin
                if (rx_byte == gfp_pkg::SYNC_SECOND)
                    phase_next = gfp_pkg::PH_CLASS;
                else if (rx_byte != gfp_pkg::SYNC_FIRST)
                    phase_next = gfp_pkg::PH_HUNT;
            end
            gfp_pkg::PH_CLASS:
            begin
                class_next = rx_byte;
                sum_a_next = rx_byte;
                sum_b_next = rx_byte;
                phase_next = gfp_pkg::PH_ID;
            end
            gfp_pkg::PH_ID:
            begin
                sum_a_next = add_a;
                sum_b_next = add_b;
                id_next    = rx_byte;
                phase_next = gfp_pkg::PH_LEN_LO;
            end
            gfp_pkg::PH_LEN_LO:
            begin
                sum_a_next = add_a;
                sum_b_next = add_b;
                len_next   = {8'd0, rx_byte};
                phase_next = gfp_pkg::PH_LEN_HI;
            end
            gfp_pkg::PH_LEN_HI:
            begin
                sum_a_next = add_a;
                sum_b_next = add_b;
                len_next   = full_len;
                count_next = '0;
                if (full_len > max_len)
                begin
                    phase_next       = gfp_pkg::PH_HUNT;
                    res_valid        = 1'b1;
                    res.kind         = gfp_pkg::KIND_ABORT;
                    res.frame_class  = class_reg;
                    res.frame_id     = id_reg;
                    res.frame_length = full_len;
                end
                else if (full_len == 16'd0)
                    phase_next = gfp_pkg::PH_CHECK_A;
                else
                    phase_next = gfp_pkg::PH_PAYLOAD;
            end
            gfp_pkg::PH_PAYLOAD:
            begin
                sum_a_next = add_a;
                sum_b_next = add_b;
                count_next = count_inc;
                if (count_inc == len_reg)
                    phase_next = gfp_pkg::PH_CHECK_A;
                res_valid        = 1'b1;
                res.kind         = gfp_pkg::KIND_PAYLOAD;
                res.data_byte    = rx_byte;
                res.frame_class  = class_reg;
                res.frame_id     = id_reg;
                res.byte_index   = count_reg;
                res.frame_length = len_reg;
            end
            gfp_pkg::PH_CHECK_A:
            begin
                if (rx_byte != sum_a_reg)
                begin
                    // first check byte wrong: end now, next byte is hunted
                    phase_next       = gfp_pkg::PH_HUNT;
                    res_valid        = 1'b1;
                    res.kind         = gfp_pkg::KIND_END;
                    res.frame_class  = class_reg;
                    res.frame_id     = id_reg;
                    res.frame_length = len_reg;
                    res.check_status = gfp_pkg::STATUS_BAD_A;
                end
                else
                    phase_next = gfp_pkg::PH_CHECK_B;
            end
            gfp_pkg::PH_CHECK_B:
            begin
                phase_next       = gfp_pkg::PH_HUNT;
                res_valid        = 1'b1;
                res.kind         = gfp_pkg::KIND_END;
                res.frame_class  = class_reg;
                res.frame_id     = id_reg;
                res.frame_length = len_reg;
                res.check_status = (rx_byte != sum_b_reg) ? gfp_pkg::STATUS_BAD_B
                                                          : gfp_pkg::STATUS_OK;
            end
            default:
            begin
                if (rx_byte == gfp_pkg::SYNC_FIRST)
                    phase_next = gfp_pkg::PH_SYNC2;
                else
                begin
                    phase_next    = gfp_pkg::PH_HUNT;
                    res_valid     = 1'b1;
                    res.kind      = gfp_pkg::KIND_TEXT;
                    res.data_byte = rx_byte;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= gfp_pkg::PH_HUNT;
            class_reg <= '0;
            id_reg    <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            class_reg <= class_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

endmodule

@@ rtl/core/gfp_out_skid.sv @@
// gfp_out_skid: result register plus one skid entry.
// Depends on gfp_pkg. Upstream stall is a flop, not a path from out_stall.
module gfp_out_skid
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  gfp_pkg::result_t  push_data,
    output logic              full,
    output logic              out_valid,
    output gfp_pkg::result_t  out_data,
    input  logic              out_stall
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    gfp_pkg::result_t out_data_reg, out_data_next;
    gfp_pkg::result_t skid_data_reg, skid_data_next;
    logic             take;

    assign take = out_valid_reg & ~out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // no push can arrive while the skid entry is held
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/core/binary_gps_frame_parser_unit.sv @@
// Binary GPS frame parser: sync hunt, header, payload and Fletcher-8 check.
// Latency: a result is valid the cycle after its item is accepted when the
// result register is free; behind a stalled result it waits in the skid entry.
// Throughput: one item per cycle while in_stall is low; set by the parse step.
// in_stall rises only when both the result register and the skid entry are full.
// Reset (rst_n, async low): hunting for sync, sums and header cleared,
// max_payload_len back to 512, no result pending.
module binary_gps_frame_parser_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: max_payload_len
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // received byte item
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    // result item
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [7:0]  frame_class,
    output logic [7:0]  frame_id,
    output logic [15:0] byte_index,
    output logic [15:0] frame_length,
    output logic [1:0]  check_status
);

    logic [15:0]      max_len_reg;
    logic             accept;
    logic             res_valid;
    logic             buf_full;
    gfp_pkg::result_t res;
    gfp_pkg::result_t out_data;

    // largest accepted payload length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= gfp_pkg::MAX_LEN_RESET;
        else if (cfg_wr_en)
            max_len_reg <= cfg_wr_data;
    end

    // an item is taken whenever the skid entry is free
    assign in_stall = buf_full;
    assign accept   = in_valid & ~buf_full;

    gfp_parse_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register with skid so the parser keeps running while out is stalled, until the skid entry fills
    gfp_out_skid u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept & res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_stall (out_stall)
    );

    assign kind         = out_data.kind;
    assign data_byte    = out_data.data_byte;
    assign frame_class  = out_data.frame_class;
    assign frame_id     = out_data.frame_id;
    assign byte_index   = out_data.byte_index;
    assign frame_length = out_data.frame_length;
    assign check_status = out_data.check_status;

endmodule

@@ verif/tb_binary_gps_frame_parser_unit.sv @@
// Testbench for binary_gps_frame_parser_unit: drives received bytes, predicts every result
// and checks it field by field. Depends on gfp_pkg and the RTL only; needs no other files.
module tb_binary_gps_frame_parser_unit;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 8;     // margin; a result is registered after its byte
    localparam int HOLD_CYCLES    = 60;    // long receiver hold-off to fill the block
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either side

    // how a generated frame is damaged
    typedef enum {FLAW_NONE, FLAW_SUM_A, FLAW_SUM_B} frame_flaw_t;

    // ------------------------------------------------------------------
    // Scoreboard: own copy of the parser state, expected results in order
    // ------------------------------------------------------------------
    class frame_scoreboard;
        gfp_pkg::phase_t  phase;
        logic [15:0]      max_len;
        logic [7:0]       cur_class;
        logic [7:0]       cur_id;
        logic [15:0]      cur_len;
        logic [15:0]      pay_count;
        logic [7:0]       sum_a;
        logic [7:0]       sum_b;
        gfp_pkg::result_t awaited_results[$];
        int               errors;
        int               bytes_in;
        int               kind_seen[4];
        int               status_seen[3];

        function new();
            phase     = gfp_pkg::PH_HUNT;
            max_len   = gfp_pkg::MAX_LEN_RESET;
            cur_class = '0;
            cur_id    = '0;
            cur_len   = '0;
            pay_count = '0;
            sum_a     = '0;
            sum_b     = '0;
            errors    = 0;
            bytes_in  = 0;
        endfunction

        function void set_max_len(logic [15:0] v);
            max_len = v;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void fold(logic [7:0] b);
            sum_a = sum_a + b;
            sum_b = sum_b + sum_a;
        endfunction

        function gfp_pkg::result_t frame_result(logic [1:0] k);
            gfp_pkg::result_t r;
            r              = '0;
            r.kind         = k;
            r.frame_class  = cur_class;
            r.frame_id     = cur_id;
            r.frame_length = cur_len;
            return r;
        endfunction

        // advance the parser by one accepted byte
        function void note_byte(logic [7:0] b);
            gfp_pkg::result_t r;
            bit               emits;
            r     = '0;
            emits = 1'b0;
            bytes_in++;
            case (phase)
                gfp_pkg::PH_SYNC2:
                begin
                    if (b == gfp_pkg::SYNC_SECOND)
                        phase = gfp_pkg::PH_CLASS;
                    else if (b != gfp_pkg::SYNC_FIRST)
                        phase = gfp_pkg::PH_HUNT;
                end
                gfp_pkg::PH_CLASS:
                begin
                    cur_class = b;
                    sum_a     = b;
                    sum_b     = b;
                    phase     = gfp_pkg::PH_ID;
                end
                gfp_pkg::PH_ID:
                begin
                    fold(b);
                    cur_id = b;
                    phase  = gfp_pkg::PH_LEN_LO;
                end
                gfp_pkg::PH_LEN_LO:
                begin
                    fold(b);
                    cur_len = {8'h00, b};
                    phase   = gfp_pkg::PH_LEN_HI;
                end
                gfp_pkg::PH_LEN_HI:
                begin
                    fold(b);
                    cur_len[15:8] = b;
                    pay_count     = '0;
                    if (cur_len > max_len)
                    begin
                        phase = gfp_pkg::PH_HUNT;
                        r     = frame_result(gfp_pkg::KIND_ABORT);
                        emits = 1'b1;
                    end
                    else if (cur_len == 16'd0)
                        phase = gfp_pkg::PH_CHECK_A;
                    else
                        phase = gfp_pkg::PH_PAYLOAD;
                end
                gfp_pkg::PH_PAYLOAD:
                begin
                    r            = frame_result(gfp_pkg::KIND_PAYLOAD);
                    r.data_byte  = b;
                    r.byte_index = pay_count;
                    emits        = 1'b1;
                    fold(b);
                    pay_count = pay_count + 16'd1;
                    if (pay_count == cur_len)
                        phase = gfp_pkg::PH_CHECK_A;
                end
                gfp_pkg::PH_CHECK_A:
                begin
                    if (b != sum_a)
                    begin
                        phase          = gfp_pkg::PH_HUNT;
                        r              = frame_result(gfp_pkg::KIND_END);
                        r.check_status = gfp_pkg::STATUS_BAD_A;
                        emits          = 1'b1;
                    end
                    else
                        phase = gfp_pkg::PH_CHECK_B;
                end
                gfp_pkg::PH_CHECK_B:
                begin
                    phase          = gfp_pkg::PH_HUNT;
                    r              = frame_result(gfp_pkg::KIND_END);
                    r.check_status = (b != sum_b) ? gfp_pkg::STATUS_BAD_B : gfp_pkg::STATUS_OK;
                    emits          = 1'b1;
                end
                default:
                begin
                    if (b == gfp_pkg::SYNC_FIRST)
                        phase = gfp_pkg::PH_SYNC2;
                    else
                    begin
                        phase       = gfp_pkg::PH_HUNT;
                        r.kind      = gfp_pkg::KIND_TEXT;
                        r.data_byte = b;
                        emits       = 1'b1;
                    end
                end
            endcase
            if (emits)
                awaited_results.push_back(r);
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $error("%s mismatch: expected %0h, got %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(gfp_pkg::result_t got);
            gfp_pkg::result_t want;
            if (awaited_results.size() == 0)
            begin
                $error("result with nothing expected: kind %0h data_byte %0h",
                       got.kind, got.data_byte);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            kind_seen[want.kind]++;
            if (want.kind == gfp_pkg::KIND_END)
                status_seen[want.check_status]++;
            compare("kind", 16'(want.kind), 16'(got.kind));
            compare("data_byte", 16'(want.data_byte), 16'(got.data_byte));
            compare("frame_class", 16'(want.frame_class), 16'(got.frame_class));
            compare("frame_id", 16'(want.frame_id), 16'(got.frame_id));
            compare("byte_index", want.byte_index, got.byte_index);
            compare("frame_length", want.frame_length, got.frame_length);
            compare("check_status", 16'(want.check_status), 16'(got.check_status));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block signals; every input known from time zero
    // ------------------------------------------------------------------
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte     = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic [15:0] byte_index;
    logic [15:0] frame_length;
    logic [1:0]  check_status;

    frame_scoreboard sb;
    logic [7:0]      tx_bytes[$];     // bytes waiting to go onto the link
    logic [15:0]     cfg_limit;       // max payload length the block currently holds
    int              limit_writes;
    int              hold_asked;      // long hold-offs requested by the main sequence
    int              hold_served;

    binary_gps_frame_parser_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .frame_class  (frame_class),
        .frame_id     (frame_id),
        .byte_index   (byte_index),
        .frame_length (frame_length),
        .check_status (check_status)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Receiver: check each accepted result, then pick next cycle's stall.
    // Stall rate changes in stretches (zero stall included); a requested
    // hold-off keeps stall high until hold_left runs down so the block backs up.
    // ------------------------------------------------------------------
    int stall_pct  = 0;
    int mode_left  = 0;
    int hold_left  = 0;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(gfp_pkg::result_t'{kind, data_byte, frame_class, frame_id,
                                               byte_index, frame_length, check_status});
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_served < hold_asked)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(30, 200);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            mode_left--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // watchdog: ends the run if nothing moves for too long
    int idle_cycles;
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no item moved for %0d cycles, %0d results still expected",
               WATCHDOG_LIMIT, sb.pending());
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus builders: append bytes to tx_bytes
    // ------------------------------------------------------------------

    // full frame with correct or damaged check bytes; extra_sync adds that many leading 0xB5 bytes
    function automatic void queue_frame(logic [7:0] cls, logic [7:0] fid, logic [15:0] len,
                                        frame_flaw_t flaw, int extra_sync);
        logic [7:0] hdr[4];
        logic [7:0] fa;
        logic [7:0] fb;
        logic [7:0] p;
        fa  = '0;
        fb  = '0;
        hdr = '{cls, fid, len[7:0], len[15:8]};
        repeat (extra_sync) tx_bytes.push_back(gfp_pkg::SYNC_FIRST);
        tx_bytes.push_back(gfp_pkg::SYNC_FIRST);
        tx_bytes.push_back(gfp_pkg::SYNC_SECOND);
        foreach (hdr[i])
        begin
            tx_bytes.push_back(hdr[i]);
            fa = fa + hdr[i];
            fb = fb + fa;
        end
        for (int i = 0; i < len; i++)
        begin
            // sync values inside the payload must not confuse the parser
            case ($urandom_range(0, 9))
                0: p = gfp_pkg::SYNC_FIRST;
                1: p = gfp_pkg::SYNC_SECOND;
                default: p = 8'($urandom);
            endcase
            tx_bytes.push_back(p);
            fa = fa + p;
            fb = fb + fa;
        end
        tx_bytes.push_back((flaw == FLAW_SUM_A) ? (fa ^ 8'($urandom_range(1, 255))) : fa);
        tx_bytes.push_back((flaw == FLAW_SUM_B) ? (fb ^ 8'($urandom_range(1, 255))) : fb);
    endfunction

    // header only; the declared length is over the limit so the frame aborts
    function automatic void queue_oversize(logic [7:0] cls, logic [7:0] fid,
                                           logic [15:0] len);
        tx_bytes.push_back(gfp_pkg::SYNC_FIRST);
        tx_bytes.push_back(gfp_pkg::SYNC_SECOND);
        tx_bytes.push_back(cls);
        tx_bytes.push_back(fid);
        tx_bytes.push_back(len[7:0]);
        tx_bytes.push_back(len[15:8]);
    endfunction

    // mostly well-formed random frames, some damaged or oversize, plus text
    // noise and truncated headers; allow_broken is off where a huge limit
    // would let a broken header swallow the rest of the phase as payload
    function automatic void queue_random_traffic(int n_bytes, bit allow_broken);
        int          target;
        int          pick;
        int          lim;
        logic [15:0] len;
        logic [7:0]  cls;
        target = tx_bytes.size() + n_bytes;
        lim    = (cfg_limit < 16'd12) ? int'(cfg_limit) : 12;
        while (tx_bytes.size() < target)
        begin
            pick = $urandom_range(0, 99);
            cls  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 10)) : 8'($urandom);
            if (pick < 83 && !(pick >= 75 && cfg_limit == 16'hFFFF))
            begin
                if (pick >= 75)
                begin
                    // just past the limit, or anywhere above it
                    if ($urandom_range(0, 1) == 0)
                        len = cfg_limit + 16'd1;
                    else
                        len = 16'($urandom_range(int'(cfg_limit) + 1, 65535));
                    queue_oversize(cls, 8'($urandom), len);
                end
                else
                begin
                    len = ($urandom_range(0, 4) == 0) ? 16'(lim) : 16'($urandom_range(0, lim));
                    queue_frame(cls, 8'($urandom), len,
                                (pick < 55) ? FLAW_NONE :
                                (pick < 65) ? FLAW_SUM_A : FLAW_SUM_B,
                                ($urandom_range(0, 7) == 0) ? 1 : 0);
                end
            end
            else if (pick < 92 || !allow_broken)
            begin
                // text between frames, now and then a lone first sync byte
                repeat ($urandom_range(1, 6))
                    tx_bytes.push_back(($urandom_range(0, 5) == 0) ? gfp_pkg::SYNC_FIRST
                                                                   : 8'($urandom));
            end
            else
            begin
                // sync then a header cut short; later bytes finish it
                tx_bytes.push_back(gfp_pkg::SYNC_FIRST);
                tx_bytes.push_back(gfp_pkg::SYNC_SECOND);
                repeat ($urandom_range(0, 3)) tx_bytes.push_back(8'($urandom));
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------

    // offer one byte and hold it until the block takes it
    task automatic send_byte(logic [7:0] b);
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_byte(b);
    endtask

    // drain tx_bytes in bursts of random length with random gaps between
    task automatic send_stream();
        int burst;
        int gap;
        while (tx_bytes.size() > 0)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && tx_bytes.size() > 0)
            begin
                send_byte(tx_bytes.pop_front());
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0 || tx_bytes.size() == 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // all expected results in, then a few cycles for bytes that give none
    task automatic wait_idle();
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_len(logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_max_len(v);
        cfg_limit = v;
        limit_writes++;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        sb           = new();
        cfg_limit    = gfp_pkg::MAX_LEN_RESET;
        limit_writes = 0;
        hold_asked   = 0;
        hold_served  = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: text extremes, abandoned repeated sync, empty frame after a
        // repeated sync, length one past the reset limit, bad first check byte
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'hFF);
        tx_bytes.push_back(gfp_pkg::SYNC_FIRST);
        tx_bytes.push_back(gfp_pkg::SYNC_FIRST);
        tx_bytes.push_back(8'h11);
        queue_frame(8'hFF, 8'h00, 16'd0, FLAW_NONE, 1);
        queue_oversize(8'h00, 8'hFF, gfp_pkg::MAX_LEN_RESET + 16'd1);
        queue_frame(8'h01, 8'h07, 16'd0, FLAW_SUM_A, 0);
        send_stream();

        // random traffic at the reset limit
        queue_random_traffic(90, 1'b1);
        send_stream();
        wait_idle();

        // limit zero: only empty payloads get through
        write_max_len(16'h0000);
        queue_random_traffic(70, 1'b1);
        send_stream();
        wait_idle();

        // widest limit, one long frame, and the receiver holding off at the start
        write_max_len(16'hFFFF);
        hold_asked++;
        queue_frame(8'h0A, 8'h5C, 16'd120, FLAW_NONE, 0);
        queue_random_traffic(70, 1'b0);
        send_stream();
        wait_idle();

        // small random limit so frames often land right at the edge
        write_max_len(16'($urandom_range(1, 40)));
        queue_random_traffic(90, 1'b1);
        send_stream();
        wait_idle();

        write_max_len(gfp_pkg::MAX_LEN_RESET);
        queue_random_traffic(70, 1'b1);
        send_stream();
        wait_idle();

        $display("Run covered %0d bytes in: %0d text, %0d payload, %0d oversize aborts.",
                 sb.bytes_in, sb.kind_seen[gfp_pkg::KIND_TEXT],
                 sb.kind_seen[gfp_pkg::KIND_PAYLOAD], sb.kind_seen[gfp_pkg::KIND_ABORT]);
        $display("Frame ends %0d ok, %0d bad first check, %0d bad second check; %0d limits.",
                 sb.status_seen[gfp_pkg::STATUS_OK], sb.status_seen[gfp_pkg::STATUS_BAD_A],
                 sb.status_seen[gfp_pkg::STATUS_BAD_B], limit_writes);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
